// ===== src/ftp_pkg.sv =====
// Package for the fixed-point trigonometric polynomial unit.
// Holds the command codes, the series coefficients, the pipeline depth and the Q-format
// multiply helper. It depends on nothing else.
package ftp_pkg;

    typedef enum logic [1:0] {
        CMD_TAN     = 2'd0,
        CMD_ASIN    = 2'd1,
        CMD_ACOS    = 2'd2,
        CMD_RAD2DEG = 2'd3
    } cmd_t;

    localparam int NUM_TERMS = 5;
    // Stage 0 prepares the operand, stages 1..POLY_LAST run the power and term
    // multiplies, and the output register follows.
    localparam int POLY_LAST = 2 * NUM_TERMS - 1;
    localparam int NUM_STG   = POLY_LAST + 2;
    localparam int TERM_W    = $clog2(NUM_TERMS);

    localparam logic [31:0] ONE_Q14     = 32'd16384;
    localparam logic [31:0] HALF_PI_Q29 = 32'd843314857;
    localparam logic [32:0] DEG_PER_RAD = 33'(64'd30760437400 >> 2);

    localparam logic signed [31:0] TAN_COEF [NUM_TERMS] = '{
        32'sd536870912, 32'sd178956971, 32'sd71582788, 32'sd28973986, 32'sd11741092
    };
    localparam logic signed [31:0] ASIN_COEF [NUM_TERMS] = '{
        32'sd536870912, 32'sd89478485, 32'sd40265318, 32'sd23967451, 32'sd16311182
    };

    // Q2.29 multiply: bits [60:29] of the full signed product.
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p[60:29];
    endfunction

endpackage

// ===== src/fixed_trig_poly_unit.sv =====
// Top level of the fixed-point trigonometric polynomial unit (tan, asin, acos, rad2deg).
// Uses ftp_pkg for command codes, coefficients and the Q2.29 multiply.
// Self-contained: no submodules.
//
// Usage notes:
// A request enters on the s_axis channel: tuser carries the 2-bit command
// (0 tan, 1 arcsine, 2 arccosine, 3 radians to degrees) and tdata the 32-bit
// signed operand. One 32-bit signed result per request leaves on m_axis tdata.
// The unit is an 11-stage pipeline: an operand preparation stage, nine stages
// of the odd power series (one 32x32 multiply each for the power chain x^2k+1,
// with the coefficient multiply-accumulate sharing alternate stages), and an
// output register that restores the sign or forms pi/2 minus the series.
// One request can be taken in every cycle while m_axis is not stalled; the depth
// is set by the chain of eight dependent power multiplies plus the final term.
// Each stage carries its own valid bit and moves whenever the stage ahead is
// empty or moving, so bubbles are squeezed out while the receiver stalls and
// s_axis_tready drops only once every stage is full. Nothing is lost or
// repeated under stall. Reset (rst_n low, asynchronous) empties all stages;
// the datapath registers are not reset.
module fixed_trig_poly_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] result
);
    import ftp_pkg::*;

    // Per-stage payload, stages 0..POLY_LAST.
    cmd_t               cmd_reg  [POLY_LAST+1];
    cmd_t               cmd_next [POLY_LAST+1];
    logic               neg_reg  [POLY_LAST+1];
    logic               neg_next [POLY_LAST+1];
    logic signed [31:0] x_reg    [POLY_LAST+1];
    logic signed [31:0] x_next   [POLY_LAST+1];
    // Power chain value: x, x^2, x^3, x^4, x^5 ... in Q2.29.
    logic signed [31:0] p_reg    [POLY_LAST+1];
    logic signed [31:0] p_next   [POLY_LAST+1];
    // Running series sum, wrapping at 32 bits.
    logic [31:0]        sum_reg  [POLY_LAST+1];
    logic [31:0]        sum_next [POLY_LAST+1];
    // Magnitude for rad2deg in stage 0, scaled degrees from stage 1 on.
    logic [31:0]        deg_reg  [POLY_LAST+1];
    logic [31:0]        deg_next [POLY_LAST+1];

    logic [31:0]        res_reg;
    logic [31:0]        res_next;

    logic [NUM_STG-1:0] valid_reg;
    logic [NUM_STG-1:0] valid_next;
    logic [NUM_STG:0]   load;

    // Operand preparation signals.
    cmd_t               in_cmd;
    logic               in_neg;
    logic [31:0]        in_mag;
    logic [31:0]        in_magc;
    logic signed [31:0] in_v;
    logic signed [31:0] in_x;
    logic [64:0]        deg_prod;
    logic signed [31:0] coef;

    // A stage loads when it is empty or when its contents move on.
    always_comb
    begin
        load[NUM_STG] = m_axis_tready;
        for (int s = NUM_STG - 1; s >= 0; s--) begin
            load[s] = !valid_reg[s] || load[s+1];
        end
        valid_next[0] = s_axis_tvalid;
        for (int s = 1; s < NUM_STG; s++) begin
            valid_next[s] = valid_reg[s-1];
        end
    end

    assign s_axis_tready = load[0];
    assign m_axis_tvalid = valid_reg[NUM_STG-1];
    assign m_axis_tdata  = res_reg;

    // Stage 0: sign, magnitude and clamping of the operand.
    always_comb
    begin
        in_cmd  = cmd_t'(s_axis_tuser);
        in_neg  = s_axis_tdata[31];
        in_mag  = in_neg ? (32'd0 - s_axis_tdata) : s_axis_tdata;
        in_magc = (in_mag > ONE_Q14) ? ONE_Q14 : in_mag;
        in_v    = $signed(s_axis_tdata);
        if (in_v > $signed(ONE_Q14)) begin
            in_v = $signed(ONE_Q14);
        end
        if (in_v < -$signed(ONE_Q14)) begin
            in_v = -$signed(ONE_Q14);
        end
        case (in_cmd)
            CMD_TAN:  in_x = $signed(in_mag);
            CMD_ASIN: in_x = $signed({in_magc[16:0], 15'd0});
            CMD_ACOS: in_x = $signed({in_v[16:0], 15'd0});
            default:  in_x = $signed(in_mag);
        endcase
    end

    // Stage 0 loads the prepared operand. Stages 1..POLY_LAST: one power
    // multiply per stage; odd stages also add the next coefficient term, using
    // the power finished in the stage before.
    always_comb
    begin
        cmd_next[0] = in_cmd;
        neg_next[0] = in_neg;
        x_next[0]   = in_x;
        p_next[0]   = in_x;
        sum_next[0] = 32'd0;
        deg_next[0] = in_mag;

        deg_prod = 65'(deg_reg[0]) * 65'(DEG_PER_RAD);
        coef     = '0;
        for (int s = 1; s <= POLY_LAST; s++) begin
            cmd_next[s] = cmd_reg[s-1];
            neg_next[s] = neg_reg[s-1];
            x_next[s]   = x_reg[s-1];
            p_next[s]   = qmul(x_reg[s-1], p_reg[s-1]);
            deg_next[s] = deg_reg[s-1];
            sum_next[s] = sum_reg[s-1];
            if (s[0]) begin
                coef = (cmd_reg[s-1] == CMD_TAN) ? TAN_COEF[TERM_W'(s >> 1)]
                                                 : ASIN_COEF[TERM_W'(s >> 1)];
                sum_next[s] = sum_reg[s-1] + 32'(qmul(coef, p_reg[s-1]));
            end
        end
        deg_next[1] = {1'b0, deg_prod[63:33]};
    end

    // Output stage: sign restore, or pi/2 minus the series for arccosine.
    always_comb
    begin
        case (cmd_reg[POLY_LAST])
            CMD_TAN,
            CMD_ASIN: res_next = neg_reg[POLY_LAST] ? (32'd0 - sum_reg[POLY_LAST])
                                                    : sum_reg[POLY_LAST];
            CMD_ACOS: res_next = HALF_PI_Q29 - sum_reg[POLY_LAST];
            default:  res_next = neg_reg[POLY_LAST] ? (32'd0 - deg_reg[POLY_LAST])
                                                    : deg_reg[POLY_LAST];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            for (int s = 0; s < NUM_STG; s++) begin
                if (load[s]) begin
                    valid_reg[s] <= valid_next[s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= POLY_LAST; s++) begin
            if (load[s]) begin
                cmd_reg[s] <= cmd_next[s];
                neg_reg[s] <= neg_next[s];
                x_reg[s]   <= x_next[s];
                p_reg[s]   <= p_next[s];
                sum_reg[s] <= sum_next[s];
                deg_reg[s] <= deg_next[s];
            end
        end
        if (load[NUM_STG-1]) begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== src/ftp_checker.sv =====
// Port-level checker for the fixed-point trigonometric polynomial unit.
// Watches only the top-level ports; bound to fixed_trig_poly_unit below.
// No package dependency.
module ftp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // With the output free to move, every stage can move, so requests are taken.
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input blocked although the output is not stalled");

    // Reset empties the pipeline, so nothing is offered on the edge after it.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result offered after reset");

endmodule

bind fixed_trig_poly_unit ftp_checker u_ftp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
